@@ rtl/core/ppfl_pkg.sv @@
// shared constants, codes and types of the page pool allocator
`timescale 1ns / 1ps
`default_nettype none
package ppfl_pkg;

  localparam int MAX_PAGES       = 1024;
  localparam int PAGES_PER_BLOCK = 256;
  localparam int MAX_BLOCKS      = MAX_PAGES / PAGES_PER_BLOCK;
  localparam int BLK_W           = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W          = $clog2(MAX_PAGES);
  localparam int PAGE_W          = 11;
  localparam int OWNER_W         = 16;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int LIMIT_W         = 3;

  localparam logic [PAGE_W-1:0]  NO_PAGE     = 11'h7ff;
  localparam logic [OWNER_W-1:0] NO_OWNER    = 16'hffff;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_FETCH = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_LINK  = 2'd2,
    KIND_FREE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARG  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_NO_MEM   = 2'd3
  } status_t;

  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_owner_en;
    logic                wr_link_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [OWNER_W-1:0]  wr_owner;
    logic [PAGE_W-1:0]   wr_link;
  } mem_req_t;

  typedef struct packed {
    logic [OWNER_W-1:0]  owner;
    logic [PAGE_W-1:0]   link;
  } mem_rsp_t;

  function automatic logic [PAGE_W-1:0] pool_size(input logic [BLK_W-1:0] blocks);
    return PAGE_W'(32'(blocks) * PAGES_PER_BLOCK);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ppfl_req_if.sv @@
// request channel: operation kind, owner and pages
`timescale 1ns / 1ps
`default_nettype none
interface ppfl_req_if;
  logic                           valid;
  logic                           ready;
  logic [ppfl_pkg::KIND_W-1:0]    kind;
  logic [ppfl_pkg::OWNER_W-1:0]   owner;
  logic [ppfl_pkg::PAGE_W-1:0]    page_id;
  logic [ppfl_pkg::PAGE_W-1:0]    link_from;

  modport source (output valid, kind, owner, page_id, link_from, input ready);
  modport sink   (input valid, kind, owner, page_id, link_from, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ppfl_rsp_if.sv @@
// response channel: status, pages and pool counters
`timescale 1ns / 1ps
`default_nettype none
interface ppfl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ppfl_pkg::STATUS_W-1:0]  status;
  logic [ppfl_pkg::PAGE_W-1:0]    result_page;
  logic [ppfl_pkg::PAGE_W-1:0]    next_page;
  logic [ppfl_pkg::PAGE_W-1:0]    pool_pages;
  logic [ppfl_pkg::PAGE_W-1:0]    pages_in_use;

  modport source (output valid, status, result_page, next_page, pool_pages, pages_in_use,
                  input ready);
  modport sink   (input valid, status, result_page, next_page, pool_pages, pages_in_use,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/ppfl_cfg_if.sv @@
// configuration write channel for the block limit
`timescale 1ns / 1ps
`default_nettype none
interface ppfl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppfl_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ppfl_tables.sv @@
// owner and link tables, one read and one write port each, registered read
`timescale 1ns / 1ps
`default_nettype none
module ppfl_tables (
  input  wire logic               clk,
  input  wire ppfl_pkg::mem_req_t mreq,
  output ppfl_pkg::mem_rsp_t      mrsp
);

  logic [ppfl_pkg::OWNER_W-1:0] owner_mem [ppfl_pkg::MAX_PAGES];
  logic [ppfl_pkg::PAGE_W-1:0]  link_mem  [ppfl_pkg::MAX_PAGES];

  always_ff @(posedge clk) begin
    if (mreq.wr_owner_en) begin
      owner_mem[mreq.wr_addr] <= mreq.wr_owner;
    end
    if (mreq.wr_link_en) begin
      link_mem[mreq.wr_addr] <= mreq.wr_link;
    end
    if (mreq.rd_en) begin
      mrsp.owner <= owner_mem[mreq.rd_addr];
      mrsp.link  <= link_mem[mreq.rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ppfl_ctrl.sv @@
// operation sequencer: checks, table read-modify-write, pool growth, response register
`timescale 1ns / 1ps
`default_nettype none
module ppfl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ppfl_pkg::LIMIT_W-1:0]  limit_blocks,
  ppfl_req_if.sink                           req,
  ppfl_rsp_if.source                         rsp,
  output ppfl_pkg::mem_req_t                 mreq,
  input  wire ppfl_pkg::mem_rsp_t            mrsp
);

  localparam int BW = ppfl_pkg::BLK_W;
  localparam int PW = ppfl_pkg::PAGE_W;
  localparam int AW = ppfl_pkg::ADDR_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_ALLOC = 8'b0000_0100,
    S_AREAD = 8'b0000_1000,
    S_GROW  = 8'b0001_0000,
    S_LINK1 = 8'b0010_0000,
    S_LINK2 = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t                          state, state_next;
  logic [ppfl_pkg::OWNER_W-1:0]    owner_q;
  logic [PW-1:0]                   page_q;
  logic [PW-1:0]                   from_q;
  logic [PW-1:0]                   free_head, free_head_next;
  logic [BW-1:0]                   blocks, blocks_next;
  logic [BW-1:0]                   want_q, want_q_next;
  logic [PW-1:0]                   used, used_next;
  logic [PW-1:0]                   grow_page, grow_page_next;
  logic [PW-1:0]                   grow_end, grow_end_next;
  logic [ppfl_pkg::STATUS_W-1:0]   st_q, st_q_next;
  logic [PW-1:0]                   res_q, res_q_next;
  logic [PW-1:0]                   nxt_q, nxt_q_next;

  logic [PW-1:0] pool_pages;
  logic [BW-1:0] cap;
  logic [BW:0]   want_wide;
  logic [BW-1:0] want;
  logic          out_free;
  logic          accept;
  logic          head_ok;
  logic          page_ok;
  logic          from_ok;
  logic [PW-1:0] grow_inc;

  assign pool_pages = ppfl_pkg::pool_size(blocks);
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign head_ok    = free_head < pool_pages;
  assign page_ok    = req.page_id < pool_pages;
  assign from_ok    = req.link_from < pool_pages;
  assign grow_inc   = PW'(grow_page + PW'(1));

  always_comb begin
    if (32'(limit_blocks) < ppfl_pkg::MAX_BLOCKS) begin
      cap = BW'(limit_blocks);
    end else begin
      cap = BW'(ppfl_pkg::MAX_BLOCKS);
    end
    if (blocks == '0) begin
      want_wide = (BW+1)'(1);
    end else begin
      want_wide = {blocks, 1'b0};
    end
    if (want_wide > {1'b0, cap}) begin
      want = cap;
    end else begin
      want = want_wide[BW-1:0];
    end
  end

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    blocks_next    = blocks;
    want_q_next    = want_q;
    used_next      = used;
    grow_page_next = grow_page;
    grow_end_next  = grow_end;
    st_q_next      = st_q;
    res_q_next     = res_q;
    nxt_q_next     = nxt_q;
    mreq           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          st_q_next  = ppfl_pkg::ST_OK;
          res_q_next = ppfl_pkg::NO_PAGE;
          nxt_q_next = ppfl_pkg::NO_PAGE;
          state_next = S_RESP;
          case (ppfl_pkg::kind_t'(req.kind))
            ppfl_pkg::KIND_FETCH: begin
              if (!page_ok) begin
                st_q_next = ppfl_pkg::ST_BAD_ARG;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = req.page_id[AW-1:0];
                state_next   = S_FETCH;
              end
            end
            ppfl_pkg::KIND_ALLOC: begin
              if (req.owner == ppfl_pkg::NO_OWNER) begin
                st_q_next = ppfl_pkg::ST_BAD_ARG;
              end else if (head_ok) begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = free_head[AW-1:0];
                state_next   = S_ALLOC;
              end else if (blocks < cap) begin
                want_q_next    = want;
                grow_page_next = pool_pages;
                grow_end_next  = ppfl_pkg::pool_size(want);
                state_next     = S_GROW;
              end else begin
                st_q_next = ppfl_pkg::ST_NO_MEM;
              end
            end
            ppfl_pkg::KIND_LINK: begin
              if (!page_ok || !from_ok) begin
                st_q_next = ppfl_pkg::ST_BAD_ARG;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = req.page_id[AW-1:0];
                state_next   = S_LINK1;
              end
            end
            ppfl_pkg::KIND_FREE: begin
              if (!page_ok) begin
                st_q_next = ppfl_pkg::ST_BAD_ARG;
              end else begin
                mreq.wr_owner_en = 1'b1;
                mreq.wr_link_en  = 1'b1;
                mreq.wr_addr     = req.page_id[AW-1:0];
                mreq.wr_owner    = ppfl_pkg::NO_OWNER;
                mreq.wr_link     = free_head;
                free_head_next   = req.page_id;
                if (used != '0) begin
                  used_next = PW'(used - PW'(1));
                end
              end
            end
            default: begin
              st_q_next = ppfl_pkg::ST_BAD_ARG;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (mrsp.owner != owner_q) begin
          st_q_next = ppfl_pkg::ST_MISMATCH;
        end else begin
          res_q_next = page_q;
          nxt_q_next = mrsp.link;
        end
        state_next = S_RESP;
      end
      S_GROW: begin
        mreq.wr_owner_en = 1'b1;
        mreq.wr_link_en  = 1'b1;
        mreq.wr_addr     = grow_page[AW-1:0];
        mreq.wr_owner    = ppfl_pkg::NO_OWNER;
        mreq.wr_link     = free_head;
        free_head_next   = grow_page;
        grow_page_next   = grow_inc;
        if (grow_inc == grow_end) begin
          blocks_next = want_q;
          state_next  = S_AREAD;
        end
      end
      S_AREAD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = free_head[AW-1:0];
        state_next   = S_ALLOC;
      end
      S_ALLOC: begin
        mreq.wr_owner_en = 1'b1;
        mreq.wr_link_en  = 1'b1;
        mreq.wr_addr     = free_head[AW-1:0];
        mreq.wr_owner    = owner_q;
        mreq.wr_link     = ppfl_pkg::NO_PAGE;
        res_q_next       = free_head;
        free_head_next   = mrsp.link;
        if (used < pool_pages) begin
          used_next = PW'(used + PW'(1));
        end
        state_next = S_RESP;
      end
      S_LINK1: begin
        if (mrsp.owner != owner_q) begin
          st_q_next  = ppfl_pkg::ST_MISMATCH;
          state_next = S_RESP;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = from_q[AW-1:0];
          state_next   = S_LINK2;
        end
      end
      S_LINK2: begin
        if (mrsp.owner != owner_q || mrsp.link != ppfl_pkg::NO_PAGE) begin
          st_q_next = ppfl_pkg::ST_MISMATCH;
        end else begin
          mreq.wr_link_en = 1'b1;
          mreq.wr_addr    = from_q[AW-1:0];
          mreq.wr_link    = page_q;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= ppfl_pkg::NO_PAGE;
      blocks    <= '0;
      used      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      blocks    <= blocks_next;
      used      <= used_next;
      if (state == S_RESP && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    want_q    <= want_q_next;
    grow_page <= grow_page_next;
    grow_end  <= grow_end_next;
    st_q      <= st_q_next;
    res_q     <= res_q_next;
    nxt_q     <= nxt_q_next;
    if (accept) begin
      owner_q <= req.owner;
      page_q  <= req.page_id;
      from_q  <= req.link_from;
    end
    if (state == S_RESP && out_free) begin
      rsp.status       <= st_q;
      rsp.result_page  <= res_q;
      rsp.next_page    <= nxt_q;
      rsp.pool_pages   <= pool_pages;
      rsp.pages_in_use <= used;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/page_pool_free_list_chain_table_top.sv @@
// top level of the page pool allocator with free list and owner chains
//
// channels: req (sink) carries kind, owner, page_id and link_from; rsp (source)
// returns one response per request: status, result_page, next_page,
// pool_pages and pages_in_use; cfg (sink) writes the block limit and is
// always ready.
// an allocate that finds the free list empty first grows the pool, if the
// block limit allows, writing one page per cycle into the tables; else it
// returns the no-memory status.
// one request is in flight at a time; the owner and link tables share one
// read port, so fetch and allocate each make one table read and link makes two.
// the next request is accepted in the cycle after a response enters the output
// register, even while the receiver stalls that response; a further response
// waits until the output register is taken.
// reset (synchronous, active high) empties the pool and free list, clears the
// in-use count and sets the block limit to 4; table contents need no clearing
// since pages are written as they join the pool.
`timescale 1ns / 1ps
`default_nettype none
module page_pool_free_list_chain_table_top (
  input  wire logic   clk,
  input  wire logic   rst,
  ppfl_req_if.sink    req,
  ppfl_rsp_if.source  rsp,
  ppfl_cfg_if.sink    cfg
);

  logic [ppfl_pkg::LIMIT_W-1:0] limit_blocks;
  ppfl_pkg::mem_req_t           mreq;
  ppfl_pkg::mem_rsp_t           mrsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_blocks <= ppfl_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      limit_blocks <= cfg.data;
    end
  end

  ppfl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .limit_blocks (limit_blocks),
    .req          (req),
    .rsp          (rsp),
    .mreq         (mreq),
    .mrsp         (mrsp)
  );

  ppfl_tables u_tables (
    .clk  (clk),
    .mreq (mreq),
    .mrsp (mrsp)
  );

endmodule
`default_nettype wire
